[sv/uphr_pkg.sv]
// Shared types and constants for the UDP packet header rewriter.
// No dependencies; every module of the block imports this package.
package uphr_pkg;

    // Frame geometry.
    localparam int HEADER_MAX_BYTES = 60;
    localparam int MAX_FRAME_BYTES  = 65535;
    localparam int ETH_LEN          = 14;
    localparam int UDP_HDR_LEN      = 8;
    localparam int HDR_END_MAX      = ETH_LEN + HEADER_MAX_BYTES + UDP_HDR_LEN;
    localparam int POS_CAP          = (MAX_FRAME_BYTES > HDR_END_MAX) ?
                                      MAX_FRAME_BYTES : HDR_END_MAX;
    localparam int POS_W            = $clog2(POS_CAP + 1);
    localparam int HDR_ADDR_W       = $clog2(HEADER_MAX_BYTES);
    localparam int HDR_MAX_WORDS    = HEADER_MAX_BYTES / 4;
    localparam int HLW_MIN          = 5;

    // Checksum accumulator width and the offsets of the checksum field.
    localparam int ACC_W            = 21;
    localparam int CSUM_HI_OFF      = 10;
    localparam int CSUM_LO_OFF      = 11;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_MAC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 3'd5;
    localparam int CFG_DATA_W = 48;

    // Beat payloads of the two streams.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } out_beat_t;

endpackage

[sv/uphr_hdr_ram.sv]
// Header buffer: single-port-write, single-port-read RAM with registered read data.
// Depends on uphr_pkg for the depth and address width.
module uphr_hdr_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [uphr_pkg::HDR_ADDR_W-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            rd_en,
    input  logic [uphr_pkg::HDR_ADDR_W-1:0] rd_addr,
    output logic [7:0]                      rd_data
);
    import uphr_pkg::*;

    logic [7:0] mem [HEADER_MAX_BYTES];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/uphr_csum.sv]
// IPv4 header checksum: running 16-bit word sum and ones-complement fold.
// Depends on uphr_pkg for the accumulator width.
module uphr_csum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        add_en,
    input  logic        restart,
    input  logic [15:0] addend,
    output logic [15:0] csum
);
    import uphr_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [16:0]      fold1;
    logic [15:0]      fold2;

    // The first header byte starts a fresh sum; later bytes add to it.
    always_comb begin
        acc_next = acc_reg;
        if (add_en) begin
            if (restart) begin
                acc_next = ACC_W'(addend);
            end else begin
                acc_next = acc_reg + ACC_W'(addend);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // Fold the carries back in twice, then complement.
    assign fold1 = {1'b0, acc_reg[15:0]} + 17'(acc_reg[ACC_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign csum  = ~fold2;

endmodule

[sv/udp_packet_header_rewriter.sv]
// Top level of the UDP packet header rewriter: config registers, frame parser,
// header burst sequencer and output register. Uses uphr_pkg, uphr_hdr_ram, uphr_csum.
//
//  Port group   Direction  Handshake            Payload
//  s_*          in         s_valid / s_ready    s_beat   (frame_byte, frame_end)
//  m_*          out        m_valid / m_ready    m_beat   (out_byte, out_end)
//  cfg_*        in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Bytes outside the IPv4 header pass at one per cycle; a new beat is taken while the
// output register is empty or being drained. IPv4 header bytes are absorbed at one
// per cycle into the header RAM under the same condition; the header burst then sends
// each byte by a RAM read and then a load of the output register, and no input is taken meanwhile.
// Reset is synchronous, active low; the header RAM needs no clearing pass.
// A stalled m_ready holds the output register and, in turn, the input.
module udp_packet_header_rewriter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  uphr_pkg::in_beat_t            s_beat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output uphr_pkg::out_beat_t           m_beat,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [uphr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uphr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uphr_pkg::*;

    typedef enum logic [1:0] {
        ST_STREAM,
        ST_READ,
        ST_SEND
    } state_t;

    // Configuration registers.
    logic [47:0] src_mac_reg;
    logic [47:0] dst_mac_reg;
    logic [31:0] src_ip_reg;
    logic [31:0] dst_ip_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;

    // Control state and registered outputs.
    state_t                state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [3:0]            hlw_reg, hlw_next;
    logic [HDR_ADDR_W-1:0] bcnt_reg, bcnt_next;
    logic [HDR_ADDR_W-1:0] blast_reg, blast_next;
    logic                  bcsum_reg, bcsum_next;
    logic                  bend_reg, bend_next;
    logic                  m_valid_reg, out_valid_next;
    out_beat_t             m_beat_reg, out_beat_next;

    // Datapath signals.
    logic                  in_acc;
    logic                  out_free;
    logic [5:0]            hlb;
    logic [6:0]            hdr_end;
    logic [HDR_ADDR_W-1:0] off;
    logic [POS_W-1:0]      udp_off;
    logic [7:0]            sb;
    logic [3:0]            ihl_words;
    logic                  wr_en;
    logic                  rd_en;
    logic [7:0]            rd_data;
    logic                  csum_add;
    logic                  csum_restart;
    logic [15:0]           csum_addend;
    logic [15:0]           csum;

    function automatic logic [7:0] pick_byte48(input logic [47:0] v, input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = v[47:40];
            3'd1:    r = v[39:32];
            3'd2:    r = v[31:24];
            3'd3:    r = v[23:16];
            3'd4:    r = v[15:8];
            3'd5:    r = v[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_byte32(input logic [31:0] v, input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_mac_reg  <= '0;
            dst_mac_reg  <= '0;
            src_ip_reg   <= '0;
            dst_ip_reg   <= '0;
            src_port_reg <= '0;
            dst_port_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SRC_MAC:  src_mac_reg  <= cfg_data;
                CFG_DST_MAC:  dst_mac_reg  <= cfg_data;
                CFG_SRC_IP:   src_ip_reg   <= cfg_data[31:0];
                CFG_DST_IP:   dst_ip_reg   <= cfg_data[31:0];
                CFG_SRC_PORT: src_port_reg <= cfg_data[15:0];
                CFG_DST_PORT: dst_port_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Handshakes.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_STREAM) && out_free;
    assign in_acc   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_beat   = m_beat_reg;

    // Frame geometry derived from the position and the header length.
    assign hlb     = {hlw_reg, 2'b00};
    assign hdr_end = 7'(ETH_LEN) + {1'b0, hlb};
    assign off     = HDR_ADDR_W'(pos_reg - POS_W'(ETH_LEN));
    assign udp_off = pos_reg - POS_W'(hdr_end);

    // Header byte with the IP addresses substituted.
    always_comb begin
        sb = s_beat.frame_byte;
        if (off >= HDR_ADDR_W'(12) && off < HDR_ADDR_W'(16)) begin
            sb = pick_byte32(src_ip_reg, off[1:0]);
        end else if (off >= HDR_ADDR_W'(16) && off < HDR_ADDR_W'(20)) begin
            sb = pick_byte32(dst_ip_reg, off[1:0]);
        end
    end

    // IHL with the short and long cases clamped.
    always_comb begin
        ihl_words = s_beat.frame_byte[3:0];
        if (ihl_words < 4'(HLW_MIN)) begin
            ihl_words = 4'(HLW_MIN);
        end else if (ihl_words > 4'(HDR_MAX_WORDS)) begin
            ihl_words = 4'(HDR_MAX_WORDS);
        end
    end

    assign csum_addend = off[0] ? {8'h00, sb} : {sb, 8'h00};

    // Next-state logic for the parser, the burst sequencer and the output register.
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        hlw_next       = hlw_reg;
        bcnt_next      = bcnt_reg;
        blast_next     = blast_reg;
        bcsum_next     = bcsum_reg;
        bend_next      = bend_reg;
        out_valid_next = m_valid_reg && !m_ready;
        out_beat_next  = m_beat_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        csum_add       = 1'b0;
        csum_restart   = 1'b0;

        case (state_reg)
            ST_STREAM: begin
                if (in_acc) begin
                    if (pos_reg >= POS_W'(ETH_LEN) && pos_reg < POS_W'(hdr_end)) begin
                        // IPv4 header byte: buffer it and, unless it is a checksum field byte, add it to the checksum.
                        wr_en        = 1'b1;
                        csum_add     = (off != HDR_ADDR_W'(CSUM_HI_OFF)) &&
                                       (off != HDR_ADDR_W'(CSUM_LO_OFF));
                        csum_restart = (off == '0);
                        if (off == '0) begin
                            hlw_next = ihl_words;
                        end
                        bcnt_next  = '0;
                        blast_next = off;
                        if (({1'b0, off} + 7'd1) == {1'b0, hlb}) begin
                            state_next = ST_READ;
                            bcsum_next = 1'b1;
                            bend_next  = s_beat.frame_end;
                        end else if (s_beat.frame_end) begin
                            state_next = ST_READ;
                            bcsum_next = 1'b0;
                            bend_next  = 1'b1;
                        end
                    end else begin
                        // Ethernet, UDP or payload byte goes straight out.
                        out_valid_next         = 1'b1;
                        out_beat_next.out_end  = s_beat.frame_end;
                        out_beat_next.out_byte = s_beat.frame_byte;
                        if (pos_reg < POS_W'(6)) begin
                            out_beat_next.out_byte = pick_byte48(dst_mac_reg, pos_reg[2:0]);
                        end else if (pos_reg < POS_W'(12)) begin
                            out_beat_next.out_byte =
                                pick_byte48(src_mac_reg, 3'(pos_reg - POS_W'(6)));
                        end else if (pos_reg >= POS_W'(hdr_end)) begin
                            if (udp_off < POS_W'(2)) begin
                                out_beat_next.out_byte = udp_off[0] ? src_port_reg[7:0]
                                                                    : src_port_reg[15:8];
                            end else if (udp_off < POS_W'(4)) begin
                                out_beat_next.out_byte = udp_off[0] ? dst_port_reg[7:0]
                                                                    : dst_port_reg[15:8];
                            end else if (udp_off == POS_W'(6) || udp_off == POS_W'(7)) begin
                                out_beat_next.out_byte = 8'h00;
                            end
                        end
                    end
                    // Position tracking; the last byte restarts the frame.
                    if (s_beat.frame_end) begin
                        pos_next = '0;
                        hlw_next = 4'(HLW_MIN);
                    end else if (pos_reg < POS_W'(POS_CAP)) begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_beat_next.out_byte = rd_data;
                    if (bcsum_reg && bcnt_reg == HDR_ADDR_W'(CSUM_HI_OFF)) begin
                        out_beat_next.out_byte = csum[15:8];
                    end else if (bcsum_reg && bcnt_reg == HDR_ADDR_W'(CSUM_LO_OFF)) begin
                        out_beat_next.out_byte = csum[7:0];
                    end
                    out_beat_next.out_end = (bcnt_reg == blast_reg) ? bend_reg : 1'b0;
                    if (bcnt_reg == blast_reg) begin
                        state_next = ST_STREAM;
                    end else begin
                        bcnt_next  = bcnt_reg + HDR_ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_STREAM;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_STREAM;
            pos_reg     <= '0;
            hlw_reg     <= 4'(HLW_MIN);
            bcnt_reg    <= '0;
            blast_reg   <= '0;
            bcsum_reg   <= 1'b0;
            bend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            hlw_reg     <= hlw_next;
            bcnt_reg    <= bcnt_next;
            blast_reg   <= blast_next;
            bcsum_reg   <= bcsum_next;
            bend_reg    <= bend_next;
            m_valid_reg <= out_valid_next;
        end
        m_beat_reg <= out_beat_next;
    end

    // Header buffer.
    uphr_hdr_ram u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (off),
        .wr_data (sb),
        .rd_en   (rd_en),
        .rd_addr (bcnt_reg),
        .rd_data (rd_data)
    );

    // Header checksum.
    uphr_csum u_csum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .add_en  (csum_add),
        .restart (csum_restart),
        .addend  (csum_addend),
        .csum    (csum)
    );

    // The burst never reads past the last buffered byte.
    a_burst_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_SEND) |-> (bcnt_reg <= blast_reg))
        else $error("header burst index beyond the last buffered byte");

    // A full-header burst covers exactly the header length. When the frame also
    // ended on the last header byte, the length has already returned to five.
    a_full_burst_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_READ || state_reg == ST_SEND) && bcsum_reg && !bend_reg) |->
        ({1'b0, blast_reg} + 7'd1 == {1'b0, hlb}))
        else $error("full header burst length differs from IHL");

    // The header length stays within the clamped range.
    a_hlw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hlw_reg >= 4'(HLW_MIN)) && (hlw_reg <= 4'(HDR_MAX_WORDS)))
        else $error("header length out of range");

    // A burst byte sent into a free output register shows up as valid.
    a_send_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND && out_free) |=> m_valid_reg)
        else $error("header burst byte lost");

endmodule
